@@ sv/dcs_pkg.sv @@
// Shared types and constants of the diving column selection block.
package dcs_pkg;

   localparam int LOCK_WIDTH  = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int TOL_WIDTH   = 16;
   localparam int RULE_WIDTH  = 2;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [RULE_WIDTH-1:0] RULE_FRACTIONAL = 2'd0;
   localparam logic [RULE_WIDTH-1:0] RULE_LOCKS      = 2'd1;
   localparam logic [RULE_WIDTH-1:0] RULE_VECLEN     = 2'd2;
   localparam logic [RULE_WIDTH-1:0] RULE_GUIDED     = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIVE_RULE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAXIMIZE    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GUIDE_VALID = 2'd3;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_DSTART = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_EMIT   = 6'b100000
   } dcs_state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic div_start;
      logic update;
      logic emit;
   } dcs_cmd_type;

   typedef struct packed {
      logic div_need;
      logic div_done;
      logic last;
   } dcs_status_type;

endpackage

@@ sv/dcs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dcs_div #(
   parameter int NW = 33,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW+1:0] trial;
   logic          ge;

   always_comb begin
      trial   = {1'b0, rem_ff, quo_ff[NW-1]} - {2'b00, den_ff};
      ge      = ~trial[DW+1];
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DW-1:0] : {rem_ff[DW-2:0], quo_ff[NW-1]};
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ sv/dcs_ctrl.sv @@
// Sequencer of the diving column selection block.
module dcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  dcs_pkg::dcs_status_type status,
   output dcs_pkg::dcs_cmd_type    cmd
);
   import dcs_pkg::*;

   dcs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.div_need ? ST_DSTART : ST_UPDATE;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("transfer accepted but no prep");
   a_div_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_done) |=> (state_ff == ST_UPDATE))
      else $error("divide done without update");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emit lost");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
`endif

endmodule

@@ sv/dcs_datapath.sv @@
// Scoring, running best and result register of the diving column selection block.
module dcs_datapath #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int INDEX_WIDTH   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dcs_pkg::dcs_cmd_type                   cmd,
   output dcs_pkg::dcs_status_type                status,
   input  logic                                   csr_write,
   input  logic [dcs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dcs_pkg::CSR_WIDTH-1:0]          csr_data,
   input  logic [INDEX_WIDTH-1:0]                 req_column_index,
   input  logic signed [VALUE_WIDTH-1:0]          req_lp_value,
   input  logic signed [VALUE_WIDTH-1:0]          req_lower_bound,
   input  logic signed [VALUE_WIDTH-1:0]          req_upper_bound,
   input  logic                                   req_lower_finite,
   input  logic                                   req_upper_finite,
   input  logic [dcs_pkg::LOCK_WIDTH-1:0]         req_up_lock_count,
   input  logic [dcs_pkg::LOCK_WIDTH-1:0]         req_down_lock_count,
   input  logic signed [VALUE_WIDTH-1:0]          req_objective_cost,
   input  logic [dcs_pkg::COUNT_WIDTH-1:0]        req_nonzero_count,
   input  logic signed [VALUE_WIDTH-1:0]          req_guide_value,
   input  logic                                   req_last_column,
   output logic                                   rsp_found,
   output logic [INDEX_WIDTH-1:0]                 rsp_chosen_column,
   output logic signed [VALUE_WIDTH-1:0]          rsp_target_value
);
   import dcs_pkg::*;

   localparam int W   = VALUE_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int E   = W + 2;
   localparam int SW  = W + LOCK_WIDTH + 1;
   localparam int SCW = W - 1;
   localparam int PW  = W + F + 1;
   localparam int QW  = W + 1;
   localparam int DW  = COUNT_WIDTH + 1;
   localparam int TW  = F + TOL_WIDTH + 1;
   localparam int TS_UP = (F >= TOL_WIDTH) ? F - TOL_WIDTH : 0;
   localparam int TS_DN = (F < TOL_WIDTH) ? TOL_WIDTH - F : 0;

   localparam logic [E-1:0]   ONE_E  = {{(E-1){1'b0}}, 1'b1} << F;
   localparam logic [E-1:0]   IMAX_E = {3'b000, {(W-1-F){1'b1}}, {F{1'b0}}};
   localparam logic [E-1:0]   VMIN_E = {3'b111, {(W-1){1'b0}}};
   localparam logic [SCW-1:0] VMAXU  = {SCW{1'b1}};
   localparam logic [F-1:0]   HALF   = {1'b1, {(F-1){1'b0}}};

   // configuration
   logic [RULE_WIDTH-1:0] rule_ff;
   logic [TOL_WIDTH-1:0]  tol_ff;
   logic                  max_ff;
   logic                  gvalid_ff;

   // captured column
   logic [INDEX_WIDTH-1:0]  idx_ff;
   logic [W-1:0]            v_ff, lo_ff, hi_ff, cost_ff, guide_ff;
   logic                    lof_ff, hif_ff, last_ff;
   logic [LOCK_WIDTH-1:0]   ul_ff, dl_ff;
   logic [COUNT_WIDTH-1:0]  nnz_ff;

   // prep results
   logic                    cand_ff, div_need_ff;
   logic [SCW-1:0]          score_ff;
   logic [PW-1:0]           prod_ff;
   logic [W-1:0]            target_ff;

   // running best
   logic [SCW-1:0]          lead_score_ff;
   logic [INDEX_WIDTH-1:0]  best_col_ff;
   logic [W-1:0]            best_target_ff;
   logic                    have_ff;

   logic                    found_ff;
   logic [INDEX_WIDTH-1:0]  col_out_ff;
   logic [W-1:0]            target_out_ff;

   logic [F-1:0]            frac;
   logic [F:0]              omf, frac_dist;
   logic [TW-1:0]           tol_s;
   logic                    usable, cand, def_up, lock_up, c_up, g_up, rup;
   logic [E-1:0]            down_e, up_e, guide_e, lo_ceil, hi_floor, t;
   logic [W:0]              diff, absd, cost_s, mag_c;
   logic [F:0]              mult;
   logic [PW-1:0]           prod;
   logic [LOCK_WIDTH-1:0]   lock;
   logic [SW-1:0]           raw;
   logic [SCW-1:0]          score_sat;
   logic [QW-1:0]           quotient;
   logic                    div_done;
   logic [SCW-1:0]          q_sat, upd_score;

   always_comb begin
      frac      = v_ff[F-1:0];
      down_e    = {{2{v_ff[W-1]}}, v_ff[W-1:F], {F{1'b0}}};
      up_e      = down_e + ONE_E;
      omf       = {1'b1, {F{1'b0}}} - {1'b0, frac};
      frac_dist = ({1'b0, frac} < omf) ? {1'b0, frac} : omf;
      tol_s     = (TW'(tol_ff) << TS_UP) >> TS_DN;
      usable    = !(rule_ff == RULE_GUIDED && !gvalid_ff);
      cand      = usable && (TW'(frac_dist) > tol_s);
      def_up    = (frac[F-1] && (|frac[F-2:0])) ||
                  (frac == HALF && !v_ff[W-1] && (|v_ff));

      lock_up = (ul_ff < dl_ff) || (ul_ff == dl_ff && def_up);
      lock    = lock_up ? ul_ff : dl_ff;

      cost_s  = {cost_ff[W-1], cost_ff};
      if (max_ff) cost_s = -cost_s;
      c_up    = ~cost_s[W];
      mag_c   = c_up ? cost_s : -cost_s;
      mult    = c_up ? omf : {1'b0, frac};
      prod    = PW'(mag_c * mult);

      guide_e = {{2{guide_ff[W-1]}}, guide_ff};
      g_up    = ($signed(guide_e) >= $signed(up_e));
      diff    = {v_ff[W-1], v_ff} - {guide_ff[W-1], guide_ff};
      absd    = diff[W] ? -diff : diff;

      case (rule_ff)
         RULE_LOCKS: begin
            raw = SW'({lock, {F{1'b0}}}) + SW'(frac_dist);
            rup = lock_up;
         end
         RULE_VECLEN: begin
            raw = '0;
            rup = c_up;
         end
         RULE_GUIDED: begin
            raw = SW'(absd);
            rup = g_up;
         end
         default: begin
            raw = SW'(frac_dist);
            rup = def_up;
         end
      endcase
      score_sat = (raw > SW'(VMAXU)) ? VMAXU : raw[SCW-1:0];

      t        = rup ? up_e : down_e;
      lo_ceil  = {{2{lo_ff[W-1]}}, lo_ff[W-1:F], {F{1'b0}}} +
                 ((|lo_ff[F-1:0]) ? ONE_E : '0);
      hi_floor = {{2{hi_ff[W-1]}}, hi_ff[W-1:F], {F{1'b0}}};
      if (lof_ff && $signed(t) < $signed(lo_ceil)) t = lo_ceil;
      if (hif_ff && $signed(t) > $signed(hi_floor)) t = hi_floor;
      if ($signed(t) > $signed(IMAX_E)) t = IMAX_E;
      if ($signed(t) < $signed(VMIN_E)) t = VMIN_E;

      q_sat     = (quotient > QW'(VMAXU)) ? VMAXU : quotient[SCW-1:0];
      upd_score = div_need_ff ? q_sat : score_ff;
   end

   dcs_div #(.NW(QW), .DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff[PW-1:F]),
      .divisor  (DW'(nnz_ff) + DW'(1)),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= RULE_FRACTIONAL;
         tol_ff    <= TOL_RESET;
         max_ff    <= 1'b0;
         gvalid_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIVE_RULE:   rule_ff   <= csr_data[RULE_WIDTH-1:0];
            CSR_TOLERANCE:   tol_ff    <= csr_data[TOL_WIDTH-1:0];
            CSR_MAXIMIZE:    max_ff    <= csr_data[0];
            CSR_GUIDE_VALID: gvalid_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff   <= req_column_index;
         v_ff     <= req_lp_value;
         lo_ff    <= req_lower_bound;
         hi_ff    <= req_upper_bound;
         lof_ff   <= req_lower_finite;
         hif_ff   <= req_upper_finite;
         ul_ff    <= req_up_lock_count;
         dl_ff    <= req_down_lock_count;
         cost_ff  <= req_objective_cost;
         nnz_ff   <= req_nonzero_count;
         guide_ff <= req_guide_value;
         last_ff  <= req_last_column;
      end
      if (cmd.prep) begin
         cand_ff     <= cand;
         div_need_ff <= cand && (rule_ff == RULE_VECLEN);
         score_ff    <= score_sat;
         prod_ff     <= prod;
         target_ff   <= t[W-1:0];
      end
      if (cmd.emit) begin
         found_ff      <= have_ff;
         col_out_ff    <= have_ff ? best_col_ff : '0;
         target_out_ff <= have_ff ? best_target_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff        <= 1'b0;
         lead_score_ff  <= VMAXU;
         best_col_ff    <= '0;
         best_target_ff <= '0;
      end else if (cmd.emit) begin
         have_ff        <= 1'b0;
         lead_score_ff  <= VMAXU;
         best_col_ff    <= '0;
         best_target_ff <= '0;
      end else if (cmd.update && cand_ff && (!have_ff || upd_score < lead_score_ff)) begin
         have_ff        <= 1'b1;
         lead_score_ff  <= upd_score;
         best_col_ff    <= idx_ff;
         best_target_ff <= target_ff;
      end
   end

   always_comb begin
      status.div_need = cand && (rule_ff == RULE_VECLEN);
      status.div_done = div_done;
      status.last     = last_ff;
   end

   assign rsp_found         = found_ff;
   assign rsp_chosen_column = col_out_ff;
   assign rsp_target_value  = target_out_ff;

`ifndef ASSERT_OFF
   a_update_have: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cand_ff) |=> have_ff)
      else $error("scored column left no choice");
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !have_ff)
      else $error("search not cleared after emit");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> (best_col_ff == '0 && best_target_ff == '0))
      else $error("empty best holds data");
`endif

endmodule

@@ sv/dive_column_select.sv @@
// Top level of the diving column selection block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_stall    one column per transfer
//   rsp      out        rsp_valid/rsp_stall    choice on last column
//   csr      in         csr_write              dive_rule, tolerance, sense, guide
//
// A column passes the idle, prep and update states; under the vector length rule
// a scored column also passes the divide states of the one-bit-per-cycle divider.
// A last column adds an emit state to load the result register.
// Reset is synchronous and active high; it clears the search, state and CSRs.
// A result held by rsp_stall does not block new columns; only the next
// last column waits for it to be taken.
module dive_column_select #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int INDEX_WIDTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [dcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dcs_pkg::CSR_WIDTH-1:0]       csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [INDEX_WIDTH-1:0]              req_column_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_lp_value,
   input  logic signed [VALUE_WIDTH-1:0]       req_lower_bound,
   input  logic signed [VALUE_WIDTH-1:0]       req_upper_bound,
   input  logic                                req_lower_finite,
   input  logic                                req_upper_finite,
   input  logic [dcs_pkg::LOCK_WIDTH-1:0]      req_up_lock_count,
   input  logic [dcs_pkg::LOCK_WIDTH-1:0]      req_down_lock_count,
   input  logic signed [VALUE_WIDTH-1:0]       req_objective_cost,
   input  logic [dcs_pkg::COUNT_WIDTH-1:0]     req_nonzero_count,
   input  logic signed [VALUE_WIDTH-1:0]       req_guide_value,
   input  logic                                req_last_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [INDEX_WIDTH-1:0]              rsp_chosen_column,
   output logic signed [VALUE_WIDTH-1:0]       rsp_target_value
);
   import dcs_pkg::*;

   dcs_cmd_type    cmd;
   dcs_status_type status;

   dcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dcs_datapath #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .INDEX_WIDTH   (INDEX_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_column_index    (req_column_index),
      .req_lp_value        (req_lp_value),
      .req_lower_bound     (req_lower_bound),
      .req_upper_bound     (req_upper_bound),
      .req_lower_finite    (req_lower_finite),
      .req_upper_finite    (req_upper_finite),
      .req_up_lock_count   (req_up_lock_count),
      .req_down_lock_count (req_down_lock_count),
      .req_objective_cost  (req_objective_cost),
      .req_nonzero_count   (req_nonzero_count),
      .req_guide_value     (req_guide_value),
      .req_last_column     (req_last_column),
      .rsp_found           (rsp_found),
      .rsp_chosen_column   (rsp_chosen_column),
      .rsp_target_value    (rsp_target_value)
   );

endmodule
